@@ rtl/sqvs_pkg.sv @@
// Shared types, constants and table helpers for the sprite quad vertex setup block.
`timescale 1ns / 1ps
package sqvs_pkg;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_MAXP  = 1'b1;

  localparam logic [14:0] MAXP_RESET = 15'd1024;
  localparam logic [14:0] BATCH_MAX  = 15'd16384;
  localparam logic [16:0] TEX_SAT    = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] texture_id;
    logic [1:0]  shader_id;
    logic [31:0] texture_size;
    logic [47:0] dest_min;
    logic [47:0] dest_max;
    logic [47:0] src_min;
    logic [47:0] src_max;
    logic [47:0] pivot;
    logic [31:0] scale_pair;
    logic [15:0] angle;
    logic [31:0] tint;
    logic [1:0]  flip;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic [15:0]        vertex_slot;
    logic               batch_start;
    logic               last_corner;
  } out_item_t;

  // One classified sprite handed from front to back.
  typedef struct packed {
    logic signed [17:0] sin;
    logic signed [17:0] cos;
    logic signed [15:0] scx;
    logic signed [15:0] scy;
    logic signed [25:0] lx0;
    logic signed [25:0] lx1;
    logic signed [25:0] ly0;
    logic signed [25:0] ly1;
    logic signed [23:0] dminx;
    logic signed [23:0] dminy;
    logic [23:0]        u0;
    logic [23:0]        u1;
    logic [23:0]        v0;
    logic [23:0]        v1;
    logic [15:0]        tw;
    logic [15:0]        th;
    logic [31:0]        tint;
    logic [13:0]        pos;
    logic               fresh;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_SIN, F_COS, F_PUSH} front_state_t;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_SCALE, B_MUL, B_SUM, B_OUT} back_state_t;

  // First-quadrant sine, Q14 quarter-turn in, Q16 out. Elaboration only.
  function automatic logic signed [17:0] quarter_sine(input logic [14:0] r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned rs;
    x = (longint'(r) * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        default: term = term / 110;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    rs = (longint'(sum) + 8192) >> 14;
    if (rs > 65536) rs = 65536;
    return 18'(rs);
  endfunction

  // Round half up from 24 extra fraction bits, saturate to signed 24.
  function automatic logic signed [23:0] round_sat24(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [39:0] r;
    t = v + 64'sd8388608;
    r = $signed(t[63:24]);
    if (r > 40'sd8388607) return 24'sh7FFFFF;
    else if (r < -40'sd8388608) return 24'sh800000;
    else return r[23:0];
  endfunction

endpackage

@@ rtl/sqvs_stream_if.sv @@
// Valid/ready stream channel carrying one payload struct.
`timescale 1ns / 1ps
interface sqvs_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/sprite_quad_vertex_setup_core.sv @@
// Top level of the sprite quad vertex setup block: registers, front, queue, back.
`timescale 1ns / 1ps
// Each sprite transfer on in_if yields four vertex transfers on out_if, in the
// order top-left, top-right, bottom-right, bottom-left. In the back end a sprite
// passes through the four bit-serial texture dividers (one quotient bit per
// cycle), the scale products and, per vertex, corner multiply, sum with round and
// saturate, and transfer. The front end classifies the next sprite (batch, sine
// and cosine lookup) while the back end works, and a two-entry queue sits between
// them. Register 0 (byte 0) is depth_value, register 1 (byte 4) max_portion;
// write them only while the block is idle.
module sprite_quad_vertex_setup_core #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sqvs_stream_if.sink  in_if,
  sqvs_stream_if.source out_if,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [23:0]    depth_r;
  logic [14:0]    maxp_r;
  logic           cfg_wr;
  logic           push, pop, q_full, q_empty;
  sqvs_pkg::job_t push_data, head;

  // APB: zero wait states; register picked by address bit 2.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == sqvs_pkg::REG_MAXP) ? {17'd0, maxp_r} : {8'd0, depth_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      maxp_r  <= sqvs_pkg::MAXP_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sqvs_pkg::REG_DEPTH) depth_r <= cfg_pwdata[23:0];
      else maxp_r <= cfg_pwdata[14:0];
    end
  end

  // front: batch tracking and trig lookup
  sqvs_front #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_front (
    .clk, .rst_n, .in_if, .max_portion(maxp_r), .push, .push_data, .q_full
  );

  sqvs_fifo #(.T(sqvs_pkg::job_t)) u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .head, .full(q_full), .empty(q_empty)
  );

  // back: divide, transform, one vertex per transfer
  sqvs_back u_back (
    .clk, .rst_n, .head, .q_empty, .pop, .depth_value(depth_r), .out_if
  );
endmodule

@@ rtl/sqvs_fifo.sv @@
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module sqvs_fifo #(parameter type T = logic [7:0]) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  input  logic pop,
  output T     head,
  output logic full,
  output logic empty
);
  T           mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

@@ rtl/sqvs_front.sv @@
// Front end: takes sprites, tracks batches, looks up sine and cosine, queues jobs.
`timescale 1ns / 1ps
module sqvs_front #(parameter int SINE_TABLE_ENTRIES = 1024) (
  input  logic                clk,
  input  logic                rst_n,
  sqvs_stream_if.sink         in_if,
  input  logic [14:0]         max_portion,
  output logic                push,
  output sqvs_pkg::job_t      push_data,
  input  logic                q_full
);
  localparam int IW = $clog2(SINE_TABLE_ENTRIES);
  typedef logic signed [17:0] sin_tab_t [SINE_TABLE_ENTRIES];

  function automatic sin_tab_t build_tab();
    sin_tab_t           t;
    logic [15:0]        f;
    logic [14:0]        r;
    logic signed [17:0] s;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      f = 16'((longint'(k) * 65536) / SINE_TABLE_ENTRIES);
      r = {1'b0, f[13:0]};
      if (f[14]) r = 15'd16384 - r;
      s = sqvs_pkg::quarter_sine(r);
      t[k] = f[15] ? -s : s;
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_tab();

  sqvs_pkg::front_state_t state_r, state_nxt;
  sqvs_pkg::in_item_t     item_r;
  logic                   fresh_r;
  logic [13:0]            pos_r;
  logic [15:0]            prev_tex_r;
  logic [1:0]             prev_shd_r;
  logic [14:0]            cnt_r;
  logic                   have_prev_r;
  logic signed [17:0]     sin_r, rom_q_r;
  logic [IW-1:0]          rom_addr;
  logic [31:0]            sin_prod, cos_prod;
  logic [15:0]            cos_ang;
  logic [14:0]            lim;
  logic                   fresh;
  logic [14:0]            pos;
  logic                   accept;

  assign accept = in_if.valid && in_if.ready;

  always_comb begin
    if (max_portion == 15'd0) lim = 15'd1;
    else if (max_portion > sqvs_pkg::BATCH_MAX) lim = sqvs_pkg::BATCH_MAX;
    else lim = max_portion;
    fresh = !have_prev_r || (in_if.data.texture_id != prev_tex_r) ||
            (in_if.data.shader_id != prev_shd_r) || (cnt_r >= lim);
    pos = fresh ? 15'd0 : cnt_r;
  end

  assign cos_ang  = item_r.angle + 16'd16384;
  assign sin_prod = {16'd0, item_r.angle} * 32'(SINE_TABLE_ENTRIES);
  assign cos_prod = {16'd0, cos_ang} * 32'(SINE_TABLE_ENTRIES);
  assign rom_addr = (state_r == sqvs_pkg::F_SIN) ? sin_prod[16 +: IW] : cos_prod[16 +: IW];

  always_ff @(posedge clk) begin
    rom_q_r <= SIN_TAB[rom_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    push        = 1'b0;
    case (state_r)
      sqvs_pkg::F_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) state_nxt = sqvs_pkg::F_SIN;
      end
      sqvs_pkg::F_SIN: state_nxt = sqvs_pkg::F_COS;
      sqvs_pkg::F_COS: state_nxt = sqvs_pkg::F_PUSH;
      sqvs_pkg::F_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = sqvs_pkg::F_IDLE;
        end
      end
      default: state_nxt = sqvs_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqvs_pkg::F_IDLE;
      prev_tex_r  <= '0;
      prev_shd_r  <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        prev_tex_r  <= in_if.data.texture_id;
        prev_shd_r  <= in_if.data.shader_id;
        cnt_r       <= pos + 15'd1;
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_if.data;
      fresh_r <= fresh;
      pos_r   <= pos[13:0];
    end
    if (state_r == sqvs_pkg::F_COS) sin_r <= rom_q_r;
  end

  // Job assembly: local corner offsets and flipped source edges.
  always_comb begin
    logic signed [23:0] dminx, dminy, dmaxx, dmaxy, px, py;
    dminx = item_r.dest_min[23:0];
    dminy = item_r.dest_min[47:24];
    dmaxx = item_r.dest_max[23:0];
    dmaxy = item_r.dest_max[47:24];
    px    = item_r.pivot[23:0];
    py    = item_r.pivot[47:24];
    push_data.sin   = sin_r;
    push_data.cos   = rom_q_r;
    push_data.scx   = item_r.scale_pair[15:0];
    push_data.scy   = item_r.scale_pair[31:16];
    push_data.lx0   = -26'(px);
    push_data.ly0   = -26'(py);
    push_data.lx1   = 26'(dmaxx) - 26'(dminx) - 26'(px);
    push_data.ly1   = 26'(dmaxy) - 26'(dminy) - 26'(py);
    push_data.dminx = dminx;
    push_data.dminy = dminy;
    push_data.u0    = item_r.flip[0] ? item_r.src_max[23:0] : item_r.src_min[23:0];
    push_data.u1    = item_r.flip[0] ? item_r.src_min[23:0] : item_r.src_max[23:0];
    push_data.v0    = item_r.flip[1] ? item_r.src_max[47:24] : item_r.src_min[47:24];
    push_data.v1    = item_r.flip[1] ? item_r.src_min[47:24] : item_r.src_max[47:24];
    push_data.tw    = (item_r.texture_size[15:0] == 16'd0) ? 16'd1 : item_r.texture_size[15:0];
    push_data.th    = (item_r.texture_size[31:16] == 16'd0) ? 16'd1
                                                            : item_r.texture_size[31:16];
    push_data.tint  = item_r.tint;
    push_data.pos   = pos_r;
    push_data.fresh = fresh_r;
  end
endmodule

@@ rtl/sqvs_div.sv @@
// Bit-serial texture coordinate divider, 17 quotient bits, saturating.
`timescale 1ns / 1ps
module sqvs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [16:0] quo
);
  logic [15:0] rem_r, d_r;
  logic [16:0] sh_r, q_r;
  logic [4:0]  cnt_r;
  logic        sat_r, busy_r;
  logic [16:0] trial;
  logic        take;

  assign busy  = busy_r;
  assign quo   = sat_r ? sqvs_pkg::TEX_SAT : q_r;
  assign trial = {rem_r, sh_r[16]};
  assign take  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 5'd0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat_r <= {1'b0, dividend[31:17]} >= divisor;
      rem_r <= {1'b0, dividend[31:17]};
      sh_r  <= dividend[16:0];
      d_r   <= divisor;
      q_r   <= '0;
      cnt_r <= 5'd16;
    end else if (busy_r) begin
      rem_r <= take ? 16'(trial - {1'b0, d_r}) : trial[15:0];
      sh_r  <= {sh_r[15:0], 1'b0};
      q_r   <= {q_r[15:0], take};
      cnt_r <= cnt_r - 5'd1;
    end
  end
endmodule

@@ rtl/sqvs_back.sv @@
// Back end: texture divides, scale and rotate, one vertex out at a time.
`timescale 1ns / 1ps
module sqvs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sqvs_pkg::job_t     head,
  input  logic               q_empty,
  output logic               pop,
  input  logic [23:0]        depth_value,
  sqvs_stream_if.source      out_if
);
  sqvs_pkg::back_state_t state_r, state_nxt;
  sqvs_pkg::job_t        job_r;
  sqvs_pkg::out_item_t   out_r;
  logic                  out_valid_r;
  logic [1:0]            corner_r;
  logic signed [33:0]    csx_r, ssx_r, csy_r, ssy_r;
  logic signed [59:0]    pa_r, pb_r, pc_r, pd_r;
  logic [3:0]            busy;
  logic [16:0]           quo [4];
  logic signed [25:0]    lx, ly;
  logic signed [63:0]    xs, ys;
  logic                  start;

  assign start = (state_r == sqvs_pkg::B_IDLE) && !q_empty;

  sqvs_div u_div_u0 (.clk, .rst_n, .start, .dividend({head.u0, 8'd0}), .divisor(head.tw),
                     .busy(busy[0]), .quo(quo[0]));
  sqvs_div u_div_u1 (.clk, .rst_n, .start, .dividend({head.u1, 8'd0}), .divisor(head.tw),
                     .busy(busy[1]), .quo(quo[1]));
  sqvs_div u_div_v0 (.clk, .rst_n, .start, .dividend({head.v0, 8'd0}), .divisor(head.th),
                     .busy(busy[2]), .quo(quo[2]));
  sqvs_div u_div_v1 (.clk, .rst_n, .start, .dividend({head.v1, 8'd0}), .divisor(head.th),
                     .busy(busy[3]), .quo(quo[3]));

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  assign lx = (corner_r == sqvs_pkg::CORNER_TR || corner_r == sqvs_pkg::CORNER_BR)
              ? job_r.lx1 : job_r.lx0;
  assign ly = (corner_r == sqvs_pkg::CORNER_BR || corner_r == sqvs_pkg::CORNER_BL)
              ? job_r.ly1 : job_r.ly0;
  assign xs = 64'(pa_r) - 64'(pb_r) + (64'(job_r.dminx) <<< 24);
  assign ys = 64'(pc_r) + 64'(pd_r) + (64'(job_r.dminy) <<< 24);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      sqvs_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = sqvs_pkg::B_DIV;
        end
      end
      sqvs_pkg::B_DIV:   if (busy == 4'd0) state_nxt = sqvs_pkg::B_SCALE;
      sqvs_pkg::B_SCALE: state_nxt = sqvs_pkg::B_MUL;
      sqvs_pkg::B_MUL:   state_nxt = sqvs_pkg::B_SUM;
      sqvs_pkg::B_SUM:   state_nxt = sqvs_pkg::B_OUT;
      sqvs_pkg::B_OUT: begin
        if (out_if.ready) begin
          state_nxt = (corner_r == sqvs_pkg::CORNER_BL) ? sqvs_pkg::B_IDLE : sqvs_pkg::B_MUL;
        end
      end
      default: state_nxt = sqvs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqvs_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      corner_r    <= sqvs_pkg::CORNER_TL;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sqvs_pkg::B_SCALE: corner_r <= sqvs_pkg::CORNER_TL;
        sqvs_pkg::B_SUM:   out_valid_r <= 1'b1;
        sqvs_pkg::B_OUT: begin
          if (out_if.ready) begin
            out_valid_r <= 1'b0;
            corner_r    <= corner_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
    if (state_r == sqvs_pkg::B_SCALE) begin
      csx_r <= job_r.cos * job_r.scx;
      ssx_r <= job_r.sin * job_r.scx;
      csy_r <= job_r.cos * job_r.scy;
      ssy_r <= job_r.sin * job_r.scy;
    end
    if (state_r == sqvs_pkg::B_MUL) begin
      pa_r <= csx_r * lx;
      pb_r <= ssy_r * ly;
      pc_r <= ssx_r * lx;
      pd_r <= csy_r * ly;
    end
    if (state_r == sqvs_pkg::B_SUM) begin
      out_r.pos_x        <= sqvs_pkg::round_sat24(xs);
      out_r.pos_y        <= sqvs_pkg::round_sat24(ys);
      out_r.pos_z        <= depth_value;
      out_r.tex_u        <= (corner_r == sqvs_pkg::CORNER_TL || corner_r == sqvs_pkg::CORNER_BL)
                            ? quo[0] : quo[1];
      out_r.tex_v        <= (corner_r == sqvs_pkg::CORNER_TL || corner_r == sqvs_pkg::CORNER_TR)
                            ? quo[2] : quo[3];
      out_r.vertex_color <= job_r.tint;
      out_r.corner       <= corner_r;
      out_r.vertex_slot  <= {job_r.pos, corner_r};
      out_r.batch_start  <= job_r.fresh && (corner_r == sqvs_pkg::CORNER_TL);
      out_r.last_corner  <= (corner_r == sqvs_pkg::CORNER_BL);
    end
  end
endmodule

@@ rtl/sqvs_checker.sv @@
// Port-level checks on the vertex stream, bound to the top level.
`timescale 1ns / 1ps
module sqvs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  corner,
  input logic [15:0] slot,
  input logic        batch_start,
  input logic        last_corner
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(corner) && $stable(slot))
    else $error("vertex changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_corner == (corner == sqvs_pkg::CORNER_BL))
    else $error("last_corner mismatch");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && batch_start |-> corner == sqvs_pkg::CORNER_TL && slot == 16'd0)
    else $error("batch start off slot zero");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slot[1:0] == corner)
    else $error("slot and corner disagree");
endmodule

bind sprite_quad_vertex_setup_core sqvs_checker u_sqvs_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_if.valid), .out_ready(out_if.ready),
  .corner(out_if.data.corner), .slot(out_if.data.vertex_slot),
  .batch_start(out_if.data.batch_start), .last_corner(out_if.data.last_corner)
);
